// ===== src/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// Depends on nothing; used by first_fit_block_allocator_top.
package ffba_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int SIZE_BITS  = 16;
  localparam int ID_W       = 8;
  localparam int OWNER_W    = 8;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    size_t              size;
    logic [OWNER_W-1:0] owner;
    logic [ID_W-1:0]    ident;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_ALLOC  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_WHOLE   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [OWNER_W-1:0] OWNER_FREE = '0;
  localparam logic [ID_W-1:0]    ID_NONE    = '0;
  localparam logic [ID_W-1:0]    ID_FIRST   = ID_W'(1);

endpackage

// ===== src/ffba_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ffba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/first_fit_block_allocator_top.sv =====
// First-fit block allocator, top level.
// Depends on ffba_pkg (types, constants) and ffba_ram (block table storage).
//
// The block table lives in one RAM with a registered read, one entry per block
// holding its size, owner and id; only the entry count and the next id sit in
// flip-flops, so nothing is cleared after reset and the block is ready at once.
// One transaction is worked at a time. An append, or an allocate refused at
// once because its owner is zero or the table is empty, goes from acceptance
// to S_RESP and puts its result into the output register from there. An
// allocate scans the table one entry per cycle through the RAM read port,
// each read issued in the cycle before the check of its data. A request that
// fits nowhere goes from the scan to S_RESP; an exact fit or a whole-block
// grant passes through S_FOUND first. A split also passes S_SHIFT, when the
// hit is not the last entry, and S_REMNANT: the shift moves the entries above
// the hit up by one to open a slot for the remainder (one entry per cycle,
// read and write ports working together). A result waits in S_RESP while the
// previous result still sits unaccepted in the output register. The input is
// ready again the cycle after the result is loaded.
// The result sits in an output register, so a new input transaction is taken
// while an earlier result still waits for out_ready.
module first_fit_block_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [7:0]  process_id,
  input  logic [15:0] size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  block_id,
  output logic [15:0] remnant_size
);

  localparam int IDX_W = ffba_pkg::IDX_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_FOUND   = 3'd2;
  localparam logic [2:0] S_SHIFT   = 3'd3;
  localparam logic [2:0] S_REMNANT = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  logic [2:0]  state;

  ffba_pkg::cnt_t count;
  logic [7:0]     next_id;

  // Transaction being worked on.
  logic [7:0]       cur_pid;
  ffba_pkg::size_t  cur_sz;

  // Scan and shift pointers.
  ffba_pkg::cnt_t rd_ptr;
  ffba_pkg::cnt_t chk_ptr;
  logic           chk_vld;
  ffba_pkg::cnt_t wr_ptr;
  logic           rd_act;
  logic           wr_act;

  // Matching entry.
  ffba_pkg::cnt_t   hit_idx;
  ffba_pkg::entry_t hit;

  // Pending result.
  logic [1:0]       res_status;
  logic [7:0]       res_id;
  ffba_pkg::size_t  res_rem;

  // RAM ports.
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  ffba_pkg::entry_t              ram_wdata;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [ffba_pkg::ENTRY_W-1:0]  ram_rdata_raw;
  ffba_pkg::entry_t              ram_rdata;

  logic             in_fire;
  ffba_pkg::size_t  in_sz;
  logic             table_full;
  logic [7:0]       id_inc;
  logic [7:0]       id_after;
  logic             chk_hit;
  ffba_pkg::size_t  hit_rem;
  logic             do_split;
  ffba_pkg::cnt_t   hit_idx_p1;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_sz      = size[ffba_pkg::SIZE_BITS-1:0];
  assign table_full = (count >= ffba_pkg::FULL_COUNT);
  assign ram_rdata  = ffba_pkg::entry_t'(ram_rdata_raw);

  // Ids count modulo 256 and skip zero.
  assign id_inc   = next_id + 8'd1;
  assign id_after = (id_inc == ffba_pkg::ID_NONE) ? ffba_pkg::ID_FIRST : id_inc;

  assign chk_hit    = (ram_rdata.owner == ffba_pkg::OWNER_FREE) && (ram_rdata.size >= cur_sz);
  assign hit_rem    = hit.size - cur_sz;
  assign do_split   = (hit_rem != '0) && !table_full;
  assign hit_idx_p1 = hit_idx + ffba_pkg::CNT_ONE;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = rd_ptr[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_fire && cmd == ffba_pkg::CMD_APPEND && !table_full) begin
          ram_we          = 1'b1;
          ram_waddr       = count[IDX_W-1:0];
          ram_wdata.size  = in_sz;
          ram_wdata.owner = ffba_pkg::OWNER_FREE;
          ram_wdata.ident = next_id;
        end
      end
      S_SCAN: begin
        ram_re = (rd_ptr < count);
      end
      S_FOUND: begin
        ram_we          = 1'b1;
        ram_waddr       = hit_idx[IDX_W-1:0];
        ram_wdata.size  = do_split ? cur_sz : hit.size;
        ram_wdata.owner = cur_pid;
        ram_wdata.ident = hit.ident;
      end
      S_SHIFT: begin
        ram_re    = rd_act;
        ram_we    = wr_act;
        ram_waddr = wr_ptr[IDX_W-1:0];
        ram_wdata = ram_rdata;
      end
      S_REMNANT: begin
        ram_we          = 1'b1;
        ram_waddr       = hit_idx_p1[IDX_W-1:0];
        ram_wdata.size  = res_rem;
        ram_wdata.owner = ffba_pkg::OWNER_FREE;
        ram_wdata.ident = next_id;
      end
      default: begin
      end
    endcase
  end

  ffba_ram #(
    .WIDTH (ffba_pkg::ENTRY_W),
    .DEPTH (ffba_pkg::MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      next_id   <= ffba_pkg::ID_FIRST;
      out_valid <= 1'b0;
      chk_vld   <= 1'b0;
      rd_act    <= 1'b0;
      wr_act    <= 1'b0;
    end else begin
      // In S_RESP the output register is reloaded below instead.
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            cur_pid <= process_id;
            cur_sz  <= in_sz;
            res_rem <= '0;
            if (cmd == ffba_pkg::CMD_APPEND) begin
              if (table_full) begin
                res_status <= ffba_pkg::ST_FULL;
                res_id     <= ffba_pkg::ID_NONE;
              end else begin
                res_status <= ffba_pkg::ST_DONE;
                res_id     <= next_id;
                next_id    <= id_after;
                count      <= count + ffba_pkg::CNT_ONE;
              end
              state <= S_RESP;
            end else if (process_id == ffba_pkg::OWNER_FREE || count == '0) begin
              // An owner of zero would mean free, and an empty table has no fit.
              res_status <= ffba_pkg::ST_NO_FIT;
              res_id     <= ffba_pkg::ID_NONE;
              state      <= S_RESP;
            end else begin
              rd_ptr  <= '0;
              chk_vld <= 1'b0;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Each read is issued in the cycle before the check of its data.
          chk_ptr <= rd_ptr;
          if (rd_ptr < count) begin
            rd_ptr <= rd_ptr + ffba_pkg::CNT_ONE;
          end
          if (chk_vld && chk_hit) begin
            hit_idx <= chk_ptr;
            hit     <= ram_rdata;
            chk_vld <= 1'b0;
            state   <= S_FOUND;
          end else if (chk_vld && (chk_ptr + ffba_pkg::CNT_ONE == count)) begin
            res_status <= ffba_pkg::ST_NO_FIT;
            res_id     <= ffba_pkg::ID_NONE;
            chk_vld    <= 1'b0;
            state      <= S_RESP;
          end else begin
            chk_vld <= (rd_ptr < count);
          end
        end
        S_FOUND: begin
          res_id <= hit.ident;
          if (hit_rem == '0) begin
            res_status <= ffba_pkg::ST_DONE;
            state      <= S_RESP;
          end else if (table_full) begin
            res_status <= ffba_pkg::ST_WHOLE;
            state      <= S_RESP;
          end else begin
            res_status <= ffba_pkg::ST_DONE;
            res_rem    <= hit_rem;
            if (hit_idx_p1 < count) begin
              // Move entries above the hit up by one, highest first.
              rd_ptr <= count - ffba_pkg::CNT_ONE;
              rd_act <= 1'b1;
              wr_act <= 1'b0;
              state  <= S_SHIFT;
            end else begin
              state <= S_REMNANT;
            end
          end
        end
        S_SHIFT: begin
          wr_ptr <= rd_ptr + ffba_pkg::CNT_ONE;
          if (rd_act) begin
            wr_act <= 1'b1;
            if (rd_ptr == hit_idx_p1) begin
              rd_act <= 1'b0;
            end else begin
              rd_ptr <= rd_ptr - ffba_pkg::CNT_ONE;
            end
          end else if (wr_act) begin
            wr_act <= 1'b0;
            state  <= S_REMNANT;
          end
        end
        S_REMNANT: begin
          next_id <= id_after;
          count   <= count + ffba_pkg::CNT_ONE;
          state   <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            block_id     <= res_id;
            remnant_size <= res_rem;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
